@@ rtl/rlst_pkg.sv @@
// shared types and constants for the running list statistics block
`timescale 1ns / 1ps

package rlst_pkg;

  // default list capacity
  localparam int unsigned CapacityDef = 64;

  // divisor width of the shared divider, wide enough for trial divisors up to 46341
  localparam int unsigned DivisorW = 16;

  // width of the divider step counter
  localparam int unsigned StepW = 7;

  // trial division runs over the 32 bits of the element
  localparam logic [StepW-1:0] PrimeSteps = 7'd32;

  // fraction bits of the mean
  localparam int unsigned FracW = 16;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME_CHK,
    S_PRIME_DIV,
    S_MEAN,
    S_MEAN_WAIT,
    S_OUT
  } rlst_state_e;

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [StepW-1:0] steps;
  } rlst_div_req_t;

endpackage

@@ rtl/rlst_div.sv @@
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rlst_div import rlst_pkg::*; #(
  parameter int unsigned DW = 54
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlst_div_req_t       req_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                done_o,
  output logic [DW-1:0]       quo_o,
  output logic [DivisorW-1:0] rem_o
);

  logic [DW-1:0]       quo_q, quo_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivisorW-1:0] div_q;
  logic [StepW-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DivisorW:0]   part;
  logic [DivisorW:0]   diff;
  logic                ge;

  // one compare and subtract step
  always_comb begin
    part  = {rem_q, quo_q[DW-1]};
    diff  = part - {1'b0, div_q};
    ge    = part >= {1'b0, div_q};
    rem_d = ge ? diff[DivisorW-1:0] : part[DivisorW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/running_list_statistics.sv @@
// top level: list statistics with a sequencer around one shared divider
//
//   channel  direction  handshake                 word
//   in       in         in_valid_i / in_stall_o   value_i
//   out      out        out_valid_o / out_stall_i accepted_o .. mean_q16_o
//
// an item that is not a prime candidate passes the mean state, the wait for the
// mean division of DW = 47 + clog2(CAPACITY + 1) divider steps and the output
// state; a value of 2 or more, taken while the list has room, first loops per
// trial divisor through a check state and a divider pass of 32 steps, up to
// about 46340 divisors
// reset clears the counts, sum, extremes and positions
// a finished word waits in the output register while the next value is taken

`timescale 1ns / 1ps

module running_list_statistics import rlst_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [6:0]         count_o,
  output logic signed [37:0] total_o,
  output logic signed [31:0] largest_o,
  output logic signed [31:0] smallest_o,
  output logic [5:0]         largest_index_o,
  output logic [5:0]         smallest_index_o,
  output logic [6:0]         even_count_o,
  output logic [6:0]         prime_count_o,
  output logic signed [47:0] mean_q16_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned MW = 31 + CW;
  localparam int unsigned DW = MW + FracW;

  rlst_state_e state_q, state_d;

  logic [CW-1:0]        count_q;
  logic [CW-1:0]        even_q;
  logic [CW-1:0]        prime_q;
  logic signed [SW-1:0] sum_q;
  logic signed [31:0]   max_q, min_q;
  logic [PW-1:0]        max_pos_q, min_pos_q;
  logic [31:0]          n_q;
  logic [15:0]          d_q;
  logic [31:0]          sq_q;
  logic                 acc_q;

  logic                 in_acc;
  logic                 has_room;
  logic                 candidate;
  logic                 out_free;
  logic                 sq_over;

  rlst_div_req_t        div_req;
  logic [DW-1:0]        div_dividend;
  logic [DivisorW-1:0]  div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic [DivisorW-1:0]  div_rem;

  logic [SW-1:0]        sum_mag;
  logic [47:0]          mean_d;

  logic                 out_valid_q;
  logic                 out_acc_q;
  logic [6:0]           out_count_q, out_even_q, out_prime_q;
  logic signed [37:0]   out_total_q;
  logic signed [31:0]   out_max_q, out_min_q;
  logic [5:0]           out_max_pos_q, out_min_pos_q;
  logic signed [47:0]   out_mean_q;

  logic [CW+6:0]        count_ext, even_ext, prime_ext;
  logic [PW+5:0]        max_pos_ext, min_pos_ext;
  logic [SW+37:0]       sum_ext;

  // handshake terms
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = count_q < CW'(CAPACITY);
  assign candidate  = !value_i[31] && (value_i[30:1] != '0);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sq_over    = sq_q > n_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (has_room && candidate) ? S_PRIME_CHK : S_MEAN;
        end
      end
      S_PRIME_CHK: state_d = sq_over ? S_MEAN : S_PRIME_DIV;
      S_PRIME_DIV: begin
        if (div_done) begin
          state_d = (div_rem == '0) ? S_MEAN : S_PRIME_CHK;
        end
      end
      S_MEAN:      state_d = S_MEAN_WAIT;
      S_MEAN_WAIT: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = PrimeSteps;
    div_dividend  = {n_q, {(DW-32){1'b0}}};
    div_divisor   = d_q;
    unique case (state_q)
      S_PRIME_CHK: div_req.start = !sq_over;
      S_MEAN: begin
        div_req.start = 1'b1;
        div_req.steps = StepW'(DW);
        div_dividend  = {sum_mag[MW-1:0], {FracW{1'b0}}};
        div_divisor   = DivisorW'(count_q);
      end
      default: ;
    endcase
  end

  assign sum_mag = sum_q[SW-1] ? -sum_q : sum_q;

  rlst_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // statistics update on accept, prime count after the trial loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      even_q    <= '0;
      prime_q   <= '0;
      sum_q     <= '0;
      max_q     <= '0;
      min_q     <= '0;
      max_pos_q <= '0;
      min_pos_q <= '0;
      acc_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        acc_q <= has_room;
        if (has_room) begin
          if (count_q == '0) begin
            max_q     <= value_i;
            min_q     <= value_i;
            max_pos_q <= '0;
            min_pos_q <= '0;
          end else begin
            if (value_i > max_q) begin
              max_q     <= value_i;
              max_pos_q <= count_q[PW-1:0];
            end
            if (value_i < min_q) begin
              min_q     <= value_i;
              min_pos_q <= count_q[PW-1:0];
            end
          end
          sum_q   <= sum_q + {{CW{value_i[31]}}, value_i};
          count_q <= count_q + 1'b1;
          if (!value_i[0]) begin
            even_q <= even_q + 1'b1;
          end
        end
      end
      if (state_q == S_PRIME_CHK && sq_over) begin
        prime_q <= prime_q + 1'b1;
      end
    end
  end

  // trial divisor and its square
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      n_q  <= value_i;
      d_q  <= 16'd2;
      sq_q <= 32'd4;
    end else if (state_q == S_PRIME_DIV && div_done) begin
      d_q  <= d_q + 1'b1;
      sq_q <= sq_q + {15'b0, d_q, 1'b1};
    end
  end

  // signed mean from the magnitude quotient
  assign mean_d = sum_q[SW-1] ? -div_quo[47:0] : div_quo[47:0];

  // outputs masked to their port widths
  assign count_ext   = {7'b0, count_q};
  assign even_ext    = {7'b0, even_q};
  assign prime_ext   = {7'b0, prime_q};
  assign max_pos_ext = {6'b0, max_pos_q};
  assign min_pos_ext = {6'b0, min_pos_q};
  assign sum_ext     = {{38{sum_q[SW-1]}}, sum_q};

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_acc_q     <= acc_q;
      out_count_q   <= count_ext[6:0];
      out_total_q   <= sum_ext[37:0];
      out_max_q     <= max_q;
      out_min_q     <= min_q;
      out_max_pos_q <= max_pos_ext[5:0];
      out_min_pos_q <= min_pos_ext[5:0];
      out_even_q    <= even_ext[6:0];
      out_prime_q   <= prime_ext[6:0];
      out_mean_q    <= mean_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign count_o          = out_count_q;
  assign total_o          = out_total_q;
  assign largest_o        = out_max_q;
  assign smallest_o       = out_min_q;
  assign largest_index_o  = out_max_pos_q;
  assign smallest_index_o = out_min_pos_q;
  assign even_count_o     = out_even_q;
  assign prime_count_o    = out_prime_q;
  assign mean_q16_o       = out_mean_q;

  // divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_PRIME_DIV || state_q == S_MEAN_WAIT))
    else $error("divider finished outside a wait state");

  // the list never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // even and prime tallies stay within the element count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (even_q <= count_q) && (prime_q <= count_q))
    else $error("tally exceeds element count");

  // a new word only follows the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output word loaded outside the output state");

  // extremes are ordered once the list holds an element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("minimum above maximum");

endmodule

@@ test/running_list_statistics_checker.sv @@
// checker: predicts list statistics per word and compares the result words
`timescale 1ns / 1ps

module running_list_statistics_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               accepted_i,
  input  logic [6:0]         count_i,
  input  logic signed [37:0] total_i,
  input  logic signed [31:0] largest_i,
  input  logic signed [31:0] smallest_i,
  input  logic [5:0]         largest_index_i,
  input  logic [5:0]         smallest_index_i,
  input  logic [6:0]         even_count_i,
  input  logic [6:0]         prime_count_i,
  input  logic signed [47:0] mean_q16_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int unsigned Capacity = rlst_pkg::CapacityDef;

  typedef struct packed {
    logic               accepted;
    logic [6:0]         count;
    logic signed [37:0] total;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic [5:0]         largest_index;
    logic [5:0]         smallest_index;
    logic [6:0]         even_count;
    logic [6:0]         prime_count;
    logic signed [47:0] mean_q16;
  } stats_t;

  // list statistics as held by the block
  int          held;
  longint      sum_acc;
  int          max_val;
  int          min_val;
  int          max_pos;
  int          min_pos;
  int          evens;
  int          primes;
  stats_t      stats_q[$];

  assign pending_o = stats_q.size();

  // trial division with a 64-bit square bound
  function automatic bit is_prime(int v);
    longint d;
    if (v < 2) return 0;
    for (d = 2; d * d <= longint'(v); d++) begin
      if (longint'(v) % d == 0) return 0;
    end
    return 1;
  endfunction

  function automatic stats_t append_value(int v);
    stats_t s;
    longint mean;
    s = '0;
    if (held < Capacity) begin
      s.accepted = 1'b1;
      if (held == 0) begin
        max_val = v;
        min_val = v;
        max_pos = 0;
        min_pos = 0;
      end else begin
        if (v > max_val) begin
          max_val = v;
          max_pos = held;
        end
        if (v < min_val) begin
          min_val = v;
          min_pos = held;
        end
      end
      sum_acc += v;
      if (v[0] == 1'b0) evens++;
      if (is_prime(v)) primes++;
      held++;
    end
    mean = (held != 0) ? (sum_acc * 64'sd65536) / longint'(held) : 0;
    s.count          = held[6:0];
    s.total          = sum_acc[37:0];
    s.largest        = max_val;
    s.smallest       = min_val;
    s.largest_index  = max_pos[5:0];
    s.smallest_index = min_pos[5:0];
    s.even_count     = evens[6:0];
    s.prime_count    = primes[6:0];
    s.mean_q16       = mean[47:0];
    return s;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    held     = 0;
    sum_acc  = 0;
    max_val  = 0;
    min_val  = 0;
    max_pos  = 0;
    min_pos  = 0;
    evens    = 0;
    primes   = 0;
  end

  // watch both channels
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) stats_q.push_back(append_value(value_i));
      if (out_valid_i && !out_stall_i) begin
        if (stats_q.size() == 0) begin
          $display("%0t: result word with no expectation", $realtime);
          errors_o++;
        end else begin
          e = stats_q.pop_front();
          if (accepted_i !== e.accepted) report("accepted", accepted_i, e.accepted);
          if (count_i !== e.count) report("count", count_i, e.count);
          if (total_i !== e.total) report("total", total_i, e.total);
          if (largest_i !== e.largest) report("largest", largest_i, e.largest);
          if (smallest_i !== e.smallest) report("smallest", smallest_i, e.smallest);
          if (largest_index_i !== e.largest_index)
            report("largest_index", largest_index_i, e.largest_index);
          if (smallest_index_i !== e.smallest_index)
            report("smallest_index", smallest_index_i, e.smallest_index);
          if (even_count_i !== e.even_count) report("even_count", even_count_i, e.even_count);
          if (prime_count_i !== e.prime_count)
            report("prime_count", prime_count_i, e.prime_count);
          if (mean_q16_i !== e.mean_q16) report("mean_q16", mean_q16_i, e.mean_q16);
        end
      end
    end
  end

endmodule

@@ test/tb_running_list_statistics.sv @@
// testbench top: stimulus, output stalls and verdict for the statistics block
`timescale 1ns / 1ps

module tb_running_list_statistics;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall;
  logic               accepted;
  logic [6:0]         count;
  logic signed [37:0] total;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;
  logic [5:0]         largest_index;
  logic [5:0]         smallest_index;
  logic [6:0]         even_count;
  logic [6:0]         prime_count;
  logic signed [47:0] mean_q16;
  int                 errors;
  int                 pending;
  int                 stall_left;

  running_list_statistics i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_o      (accepted),
    .count_o         (count),
    .total_o         (total),
    .largest_o       (largest),
    .smallest_o      (smallest),
    .largest_index_o (largest_index),
    .smallest_index_o(smallest_index),
    .even_count_o    (even_count),
    .prime_count_o   (prime_count),
    .mean_q16_o      (mean_q16)
  );

  running_list_statistics_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_i      (accepted),
    .count_i         (count),
    .total_i         (total),
    .largest_i       (largest),
    .smallest_i      (smallest),
    .largest_index_i (largest_index),
    .smallest_index_i(smallest_index),
    .even_count_i    (even_count),
    .prime_count_i   (prime_count),
    .mean_q16_i      (mean_q16),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // wait per word, with runs of no waiting
  function automatic int draw_wait();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // random value: mostly cheap to test for primality
  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9)) inside
      [0:3]:   return $urandom_range(0, 5000);
      4:       return -$urandom_range(0, 5000);
      [5:6]:   return $urandom | 32'h8000_0000;
      7:       return $urandom & 32'h7fff_fffe;
      default: return $urandom_range(0, 715827882) * 3;
    endcase
  endfunction

  // send one word, keeping valid high when no gap follows
  task automatic send_word(logic [31:0] v);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // output stall: a fresh wait for each result word
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left <= draw_wait();
  end

  initial begin
    logic [31:0] directed[$];
    in_valid   = 1'b0;
    value      = '0;
    out_stall  = 1'b0;
    stall_left = 0;
    rst_n      = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // extremes, ties, evenness of negatives, small primes and non-primes
    directed = '{32'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd2, 32'd3,
                 32'hffff_ffff, 32'hffff_fffe, 32'd4, 32'h8000_0000, 32'd2,
                 32'h7fff_fffe, 32'd97, 32'd100, 32'hffff_fff9, 32'd7919};
    foreach (directed[i]) send_word(directed[i]);
    // random part runs well past capacity, so the full list is exercised
    repeat (100) send_word(draw_value());
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule
